// ===== design/dfr_pkg.sv =====
// ----------------------------------------------------------------------------
// dfr_pkg
// Widths, constants and word types for the dielectric Fresnel refraction unit.
// ----------------------------------------------------------------------------
`default_nettype none

package dfr_pkg;

  localparam int unsigned CB   = 16;               // component width
  localparam int unsigned FB   = CB - 1;           // component fraction bits
  localparam int unsigned IB   = 16;               // index width
  localparam int unsigned IFB  = 12;               // index fraction bits
  localparam int unsigned WF   = 30;               // working fraction bits

  localparam int unsigned CRW  = WF + 2;           // clamped cosine, signed
  localparam int unsigned NUMW = WF + 1;           // 1 - cos^2
  localparam int unsigned E2W  = 2 * IB + WF - 2 * IFB;  // scaled eta^2
  localparam int unsigned TGW  = WF + 2;           // tangent magnitude
  localparam int unsigned TSW  = TGW + 2;          // tangent, signed
  localparam int unsigned TDW  = TGW + IFB;        // tangent quotient
  localparam int unsigned CTW  = WF + 1;           // refracted cosine
  localparam int unsigned S2W  = WF;               // sin^2 quotient
  localparam int unsigned RDW  = 2 * WF + 1;       // radicand
  localparam int unsigned RSW  = RDW + 1;          // root working width
  localparam int unsigned SQ_STEPS    = (RDW + 1) / 2;
  localparam int unsigned CORE_STAGES = S2W + 1 + SQ_STEPS;
  localparam int unsigned ECW  = IB + CRW - IFB + 1;  // eta*cos, signed
  localparam int unsigned AW   = ECW + 1;          // amplitude num/den
  localparam int unsigned QRW  = WF + 1;           // amplitude ratio
  localparam int unsigned SQRW = 2 * QRW - WF;     // squared ratio
  localparam int unsigned DVW  = TDW + 4;          // direction before rounding

  localparam logic [NUMW-1:0] NumOne = NUMW'(64'd1 << WF);

  typedef logic signed [CB-1:0] comp_t;

  typedef struct packed {
    comp_t          normal_x;
    comp_t          normal_y;
    comp_t          normal_z;
    comp_t          view_x;
    comp_t          view_y;
    comp_t          view_z;
    logic [IB-1:0]  refr_index;
  } dfr_in_t;

  typedef struct packed {
    comp_t          dir_x;
    comp_t          dir_y;
    comp_t          dir_z;
    logic [CB-1:0]  transmittance;
    logic           no_transmission;
  } dfr_out_t;

  // front end to divider/root core
  typedef struct packed {
    logic                  flag;
    logic [2:0][CB-1:0]    nv;
    logic [CRW-1:0]        cr;
    logic [IB-1:0]         e;
    logic [NUMW-1:0]       num;
    logic [E2W-1:0]        e2s;
    logic [2:0][TGW-1:0]   tmag;
    logic [2:0]            tneg;
  } dfr_fc_t;

  // core to Fresnel tail
  typedef struct packed {
    logic                  flag;
    logic [2:0][CB-1:0]    nv;
    logic [CRW-1:0]        cr;
    logic [IB-1:0]         e;
    logic [CTW-1:0]        ct;
    logic [2:0][TDW-1:0]   tq;
    logic [2:0]            tneg;
  } dfr_ct_t;

endpackage

`default_nettype wire

// ===== design/dielectric_fresnel_refraction_unit.sv =====
// ----------------------------------------------------------------------------
// dielectric_fresnel_refraction_unit
// Unpolarised Fresnel transmittance and refracted direction, fully pipelined.
// ----------------------------------------------------------------------------
// Throughput: one word per cycle; busy stays low, the pipeline never stalls.
// The length is set by the bit-per-stage sin^2 divider (30), root (31) and
// amplitude-ratio dividers (30) in series, plus front and tail stages.
// Reset clears only the valid bits; no result is lost, none can be held off.
`default_nettype none

module dielectric_fresnel_refraction_unit import dfr_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  output logic     busy,
  input  dfr_in_t  item_i,
  output dfr_out_t result_o,
  output logic     done_o
);

  logic    fc_v;
  dfr_fc_t fc_data;
  logic    ct_v;
  dfr_ct_t ct_data;

  assign busy = 1'b0;

  dfr_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start),
    .item_i  (item_i),
    .valid_o (fc_v),
    .data_o  (fc_data)
  );

  dfr_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (fc_v),
    .data_i  (fc_data),
    .valid_o (ct_v),
    .data_o  (ct_data)
  );

  dfr_tail u_tail (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (ct_v),
    .data_i   (ct_data),
    .valid_o  (done_o),
    .result_o (result_o)
  );

endmodule

`default_nettype wire

// ===== design/dfr_front.sv =====
// ----------------------------------------------------------------------------
// dfr_front
// Dot product, clamp, squares and tangent terms: four register stages.
// ----------------------------------------------------------------------------
`default_nettype none

module dfr_front import dfr_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    valid_i,
  input  dfr_in_t item_i,
  output logic    valid_o,
  output dfr_fc_t data_o
);

  localparam logic signed [CRW+1:0]    SumOne = (CRW+2)'(64'd1 << WF);
  localparam logic signed [CRW+CB-1:0] PnHalf = (CRW+CB)'(64'd1 << (FB - 1));

  logic [2:0] v_q;

  // stage 1
  logic signed [2*CB-1:0] p1_q [3];
  comp_t                  nv1_q [3];
  comp_t                  vv1_q [3];
  logic [IB-1:0]          e1_q;

  // stage 2
  logic signed [CRW+1:0]  sum;
  logic signed [CRW+1:0]  crc;
  logic signed [CRW-1:0]  cr2_q;
  comp_t                  nv2_q [3];
  comp_t                  vv2_q [3];
  logic [IB-1:0]          e2_q;

  // stage 3
  logic signed [2*CRW-1:0]    crsq;
  logic [NUMW-1:0]            cc3_q;
  logic [2*IB-1:0]            ee3_q;
  logic signed [CRW+CB-1:0]   pn3_q [3];
  logic signed [CRW-1:0]      cr3_q;
  comp_t                      nv3_q [3];
  comp_t                      vv3_q [3];
  logic [IB-1:0]              e3_q;

  // stage 4
  logic [NUMW-1:0]            num;
  logic [E2W-1:0]             e2s;
  logic signed [CRW+CB-1:0]   pr [3];
  logic signed [TSW-1:0]      tang [3];
  dfr_fc_t                    data_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q     <= '0;
      valid_o <= 1'b0;
    end else begin
      v_q     <= {v_q[1:0], valid_i};
      valid_o <= v_q[2];
    end
  end

  always_ff @(posedge clk_i) begin
    p1_q[0]  <= item_i.normal_x * item_i.view_x;
    p1_q[1]  <= item_i.normal_y * item_i.view_y;
    p1_q[2]  <= item_i.normal_z * item_i.view_z;
    nv1_q[0] <= item_i.normal_x;
    nv1_q[1] <= item_i.normal_y;
    nv1_q[2] <= item_i.normal_z;
    vv1_q[0] <= item_i.view_x;
    vv1_q[1] <= item_i.view_y;
    vv1_q[2] <= item_i.view_z;
    e1_q     <= item_i.refr_index;
  end

  always_comb begin
    sum = (CRW+2)'(p1_q[0]) + (CRW+2)'(p1_q[1]) + (CRW+2)'(p1_q[2]);
    if (sum > SumOne) begin
      crc = SumOne;
    end else if (sum < -SumOne) begin
      crc = -SumOne;
    end else begin
      crc = sum;
    end
  end

  always_ff @(posedge clk_i) begin
    cr2_q <= CRW'(crc);
    nv2_q <= nv1_q;
    vv2_q <= vv1_q;
    e2_q  <= e1_q;
  end

  assign crsq = cr2_q * cr2_q;

  always_ff @(posedge clk_i) begin
    cc3_q <= crsq[2*WF:WF];
    ee3_q <= e2_q * e2_q;
    for (int i = 0; i < 3; i++) begin
      pn3_q[i] <= cr2_q * nv2_q[i];
    end
    cr3_q <= cr2_q;
    nv3_q <= nv2_q;
    vv3_q <= vv2_q;
    e3_q  <= e2_q;
  end

  always_comb begin
    num = NumOne - cc3_q;
    e2s = E2W'(ee3_q) << (WF - 2 * IFB);
    data_d.flag = (e3_q == '0) || (E2W'(num) >= e2s);
    data_d.cr   = cr3_q;
    data_d.e    = e3_q;
    data_d.num  = num;
    data_d.e2s  = e2s;
    for (int i = 0; i < 3; i++) begin
      pr[i]   = (pn3_q[i] + PnHalf) >>> FB;
      tang[i] = (TSW'(vv3_q[i]) <<< FB) - TSW'(pr[i]);
      data_d.nv[i]   = nv3_q[i];
      data_d.tneg[i] = tang[i][TSW-1];
      data_d.tmag[i] = tang[i][TSW-1] ? TGW'(-tang[i]) : TGW'(tang[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    data_o <= data_d;
  end

endmodule

`default_nettype wire

// ===== design/dfr_core.sv =====
// ----------------------------------------------------------------------------
// dfr_core
// Pipelined sin^2 division, square root and tangent-by-eta divisions.
// ----------------------------------------------------------------------------
`default_nettype none

module dfr_core import dfr_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    valid_i,
  input  dfr_fc_t data_i,
  output logic    valid_o,
  output dfr_ct_t data_o
);

  typedef struct packed {
    logic                  flag;
    logic [2:0][CB-1:0]    nv;
    logic [CRW-1:0]        cr;
    logic [IB-1:0]         e;
    logic [E2W-1:0]        dv;
    logic [E2W-1:0]        rem;
    logic [S2W-1:0]        s2t;
    logic [RSW-1:0]        x;
    logic [RSW-1:0]        res;
    logic [2:0][TDW-1:0]   td;
    logic [2:0][IB-1:0]    trem;
    logic [2:0]            tneg;
  } cst_t;

  // stage k: a sin^2 quotient bit, then one radicand setup stage, then one
  // root bit; the tangent quotients take a bit a stage alongside
  function automatic cst_t step(input cst_t s, input int unsigned k);
    cst_t           o;
    logic [E2W:0]   r2;
    logic [IB:0]    t2;
    logic [RSW-1:0] bit_v;
    logic [RSW-1:0] trial;
    o = s;
    if (k < S2W) begin
      r2 = {s.rem, 1'b0};
      if (r2 >= {1'b0, s.dv}) begin
        o.rem = E2W'(r2 - {1'b0, s.dv});
        o.s2t = {s.s2t[S2W-2:0], 1'b1};
      end else begin
        o.rem = E2W'(r2);
        o.s2t = {s.s2t[S2W-2:0], 1'b0};
      end
    end else if (k == S2W) begin
      o.x   = RSW'(NumOne - NUMW'(s.s2t)) << WF;
      o.res = '0;
    end else begin
      bit_v = RSW'(1) << (2 * (CORE_STAGES - 1 - k));
      trial = s.res + bit_v;
      if (s.x >= trial) begin
        o.x   = s.x - trial;
        o.res = (s.res >> 1) + bit_v;
      end else begin
        o.res = s.res >> 1;
      end
    end
    if (k < TDW) begin
      for (int i = 0; i < 3; i++) begin
        t2 = {s.trem[i], s.td[i][TDW-1]};
        if (t2 >= {1'b0, s.e}) begin
          o.trem[i] = IB'(t2 - {1'b0, s.e});
          o.td[i]   = {s.td[i][TDW-2:0], 1'b1};
        end else begin
          o.trem[i] = IB'(t2);
          o.td[i]   = {s.td[i][TDW-2:0], 1'b0};
        end
      end
    end
    return o;
  endfunction

  cst_t                   st_in;
  cst_t                   st_q [CORE_STAGES];
  logic [CORE_STAGES-1:0] v_q;

  always_comb begin
    st_in      = '0;
    st_in.flag = data_i.flag;
    st_in.nv   = data_i.nv;
    st_in.cr   = data_i.cr;
    st_in.e    = data_i.e;
    st_in.dv   = data_i.e2s;
    st_in.rem  = E2W'(data_i.num);
    st_in.tneg = data_i.tneg;
    for (int i = 0; i < 3; i++) begin
      st_in.td[i] = {data_i.tmag[i], {IFB{1'b0}}};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[CORE_STAGES-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    st_q[0] <= step(st_in, 0);
    for (int unsigned k = 1; k < CORE_STAGES; k++) begin
      st_q[k] <= step(st_q[k-1], k);
    end
  end

  assign valid_o      = v_q[CORE_STAGES-1];
  assign data_o.flag  = st_q[CORE_STAGES-1].flag;
  assign data_o.nv    = st_q[CORE_STAGES-1].nv;
  assign data_o.cr    = st_q[CORE_STAGES-1].cr;
  assign data_o.e     = st_q[CORE_STAGES-1].e;
  assign data_o.ct    = CTW'(st_q[CORE_STAGES-1].res);
  assign data_o.tq    = st_q[CORE_STAGES-1].td;
  assign data_o.tneg  = st_q[CORE_STAGES-1].tneg;

endmodule

`default_nettype wire

// ===== design/dfr_tail.sv =====
// ----------------------------------------------------------------------------
// dfr_tail
// Amplitude ratios, reflectance, transmittance and refracted direction.
// ----------------------------------------------------------------------------
`default_nettype none

module dfr_tail import dfr_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     valid_i,
  input  dfr_ct_t  data_i,
  output logic     valid_o,
  output dfr_out_t result_o
);

  localparam int unsigned RST = WF;   // fraction steps per ratio
  localparam int unsigned NV  = 6 + RST;

  localparam logic signed [IB+CRW:0]   EcHalf = (IB+CRW+1)'(64'd1 << (IFB - 1));
  localparam logic [IB+CTW-1:0]        EtHalf = (IB+CTW)'(64'd1 << (IFB - 1));
  localparam logic signed [CTW+CB:0]   CnHalf = (CTW+CB+1)'(64'd1 << (FB - 1));
  localparam logic signed [DVW-1:0]    DHalf  = DVW'(64'd1 << (FB - 1));
  localparam logic signed [DVW-1:0]    DMax   = DVW'((64'd1 << FB) - 64'd1);
  localparam logic signed [DVW-1:0]    DMin   = ~DMax;
  localparam logic [NUMW-1:0]          TrHalf = NUMW'(64'd1 << (FB - 1));

  typedef struct packed {
    logic                  flag;
    logic [2:0][CB-1:0]    dir;
    logic [1:0][AW-1:0]    ad;
    logic [1:0][AW-1:0]    rem;
    logic [1:0][QRW-1:0]   q;
  } rst_t;

  function automatic rst_t rstep(input rst_t s);
    rst_t        o;
    logic [AW:0] r2;
    o = s;
    for (int j = 0; j < 2; j++) begin
      r2 = {s.rem[j], 1'b0};
      if (r2 >= {1'b0, s.ad[j]}) begin
        o.rem[j] = AW'(r2 - {1'b0, s.ad[j]});
        o.q[j]   = {s.q[j][QRW-2:0], 1'b1};
      end else begin
        o.rem[j] = AW'(r2);
        o.q[j]   = {s.q[j][QRW-2:0], 1'b0};
      end
    end
    return o;
  endfunction

  logic [NV-1:0] v_q;

  // E1: products
  logic                       f1_q;
  logic signed [CRW-1:0]      cr1_q;
  logic [CTW-1:0]             ct1_q;
  logic [2:0][TDW-1:0]        tq1_q;
  logic [2:0]                 tn1_q;
  logic signed [IB+CRW:0]     pecr1_q;
  logic [IB+CTW-1:0]          pect1_q;
  logic signed [CTW+CB:0]     pcn1_q [3];

  // E2: rounding, direction sums
  logic signed [IB+CRW:0]     ecr_w;
  logic [IB+CTW-1:0]          ect_w;
  logic signed [CTW+CB:0]     ctn_w [3];
  logic signed [DVW-1:0]      sct_w [3];
  logic                       f2_q;
  logic signed [CRW-1:0]      cr2_q;
  logic [CTW-1:0]             ct2_q;
  logic signed [ECW-1:0]      ecr2_q;
  logic [ECW-1:0]             ect2_q;
  logic signed [DVW-1:0]      d2_q [3];

  // E3: numerators, denominators, direction saturate
  logic signed [AW-1:0]       crs_w, cts_w, ecs_w, ets_w;
  logic signed [DVW-1:0]      rd_w [3];
  logic                       f3_q;
  logic signed [AW-1:0]       n3_q [2];
  logic signed [AW-1:0]       dd3_q [2];
  logic [2:0][CB-1:0]         dir3_q;

  // E4: magnitudes
  logic                       f4_q;
  logic [AW-1:0]              an4_q [2];
  logic [AW-1:0]              ad4_q [2];
  logic [2:0][CB-1:0]         dir4_q;

  // E5 and ratio division
  rst_t                       r_in;
  rst_t                       r_q [RST+1];

  // F1, F2
  logic                       f6_q;
  logic [2:0][CB-1:0]         dir6_q;
  logic [SQRW-1:0]            sq6_q [2];
  logic [2*QRW-1:0]           qq_w [2];
  logic [SQRW:0]              ssum;
  logic [SQRW-1:0]            fr;
  logic                       fl;
  logic [NUMW-1:0]            tw;
  logic [NUMW-1:0]            tr;
  dfr_out_t                   result_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q     <= '0;
      valid_o <= 1'b0;
    end else begin
      v_q     <= {v_q[NV-2:0], valid_i};
      valid_o <= v_q[NV-1];
    end
  end

  always_ff @(posedge clk_i) begin
    f1_q    <= data_i.flag;
    cr1_q   <= data_i.cr;
    ct1_q   <= data_i.ct;
    tq1_q   <= data_i.tq;
    tn1_q   <= data_i.tneg;
    pecr1_q <= $signed({1'b0, data_i.e}) * $signed(data_i.cr);
    pect1_q <= data_i.e * data_i.ct;
    for (int i = 0; i < 3; i++) begin
      pcn1_q[i] <= $signed({1'b0, data_i.ct}) * $signed(data_i.nv[i]);
    end
  end

  always_comb begin
    ecr_w = (pecr1_q + EcHalf) >>> IFB;
    ect_w = (pect1_q + EtHalf) >> IFB;
    for (int i = 0; i < 3; i++) begin
      ctn_w[i] = (pcn1_q[i] + CnHalf) >>> FB;
      sct_w[i] = tn1_q[i] ? -$signed(DVW'(tq1_q[i])) : $signed(DVW'(tq1_q[i]));
    end
  end

  always_ff @(posedge clk_i) begin
    f2_q   <= f1_q;
    cr2_q  <= cr1_q;
    ct2_q  <= ct1_q;
    ecr2_q <= ECW'(ecr_w);
    ect2_q <= ECW'(ect_w);
    for (int i = 0; i < 3; i++) begin
      d2_q[i] <= -sct_w[i] - DVW'(ctn_w[i]);
    end
  end

  always_comb begin
    crs_w = AW'(cr2_q);
    cts_w = $signed(AW'(ct2_q));
    ecs_w = AW'(ecr2_q);
    ets_w = $signed(AW'(ect2_q));
    for (int i = 0; i < 3; i++) begin
      rd_w[i] = (d2_q[i] + DHalf) >>> FB;
    end
  end

  always_ff @(posedge clk_i) begin
    f3_q     <= f2_q;
    n3_q[0]  <= ecs_w - cts_w;
    dd3_q[0] <= ecs_w + cts_w;
    n3_q[1]  <= crs_w - ets_w;
    dd3_q[1] <= crs_w + ets_w;
    for (int i = 0; i < 3; i++) begin
      if (rd_w[i] > DMax) begin
        dir3_q[i] <= CB'(DMax);
      end else if (rd_w[i] < DMin) begin
        dir3_q[i] <= CB'(DMin);
      end else begin
        dir3_q[i] <= CB'(rd_w[i]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    f4_q   <= f3_q;
    dir4_q <= dir3_q;
    for (int j = 0; j < 2; j++) begin
      an4_q[j] <= n3_q[j][AW-1]  ? AW'(-n3_q[j])  : AW'(n3_q[j]);
      ad4_q[j] <= dd3_q[j][AW-1] ? AW'(-dd3_q[j]) : AW'(dd3_q[j]);
    end
  end

  // integer part of each ratio is 0 or 1 once a ratio of two or more is out
  always_comb begin
    r_in      = '0;
    r_in.flag = f4_q;
    r_in.dir  = dir4_q;
    for (int j = 0; j < 2; j++) begin
      r_in.ad[j] = ad4_q[j];
      if ((ad4_q[j] == '0) || ({1'b0, an4_q[j]} >= {ad4_q[j], 1'b0})) begin
        r_in.flag = 1'b1;
      end
      if (an4_q[j] >= ad4_q[j]) begin
        r_in.rem[j] = an4_q[j] - ad4_q[j];
        r_in.q[j]   = QRW'(1);
      end else begin
        r_in.rem[j] = an4_q[j];
        r_in.q[j]   = '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    r_q[0] <= r_in;
    for (int k = 1; k <= RST; k++) begin
      r_q[k] <= rstep(r_q[k-1]);
    end
  end

  always_comb begin
    for (int j = 0; j < 2; j++) begin
      qq_w[j] = r_q[RST].q[j] * r_q[RST].q[j];
    end
  end

  always_ff @(posedge clk_i) begin
    f6_q   <= r_q[RST].flag;
    dir6_q <= r_q[RST].dir;
    for (int j = 0; j < 2; j++) begin
      sq6_q[j] <= qq_w[j][2*QRW-1:WF];
    end
  end

  always_comb begin
    ssum = {1'b0, sq6_q[0]} + {1'b0, sq6_q[1]};
    fr   = ssum[SQRW:1];
    fl   = f6_q || (fr[SQRW-1:WF] != '0);
    tw   = NumOne - NUMW'(fr[WF-1:0]);
    tr   = (tw + TrHalf) >> FB;
    result_d.no_transmission = fl;
    result_d.dir_x           = fl ? '0 : dir6_q[0];
    result_d.dir_y           = fl ? '0 : dir6_q[1];
    result_d.dir_z           = fl ? '0 : dir6_q[2];
    result_d.transmittance   = fl ? '0 : CB'(tr);
  end

  always_ff @(posedge clk_i) begin
    result_o <= result_d;
  end

endmodule

`default_nettype wire
